/* rtl/wav_pkg.sv */
package wav_pkg;

  localparam int DATA_W     = 32;
  localparam int NUM_AXES   = 3;
  localparam int NUM_QTY    = NUM_AXES + 1;
  localparam int DEF_WINDOW = 20;
  localparam int DEF_SUM_W  = DATA_W + $clog2(DEF_WINDOW);
  localparam int FIFO_DEPTH = 2;
  localparam int STEP_W     = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] SPEED_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SPEED_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_READ,
    FR_ACCUM
  } front_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NEG,
    BK_ADD,
    BK_CHECK,
    BK_DIV,
    BK_DONE
  } back_state_e;

endpackage

/* rtl/wav_ram.sv */
module wav_ram #(
  parameter int Width = 4 * wav_pkg::DATA_W,
  parameter int Depth = wav_pkg::DEF_WINDOW,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/wav_fifo.sv */
module wav_fifo #(
  parameter int Width = 4 * wav_pkg::DEF_SUM_W,
  parameter int Depth = wav_pkg::FIFO_DEPTH,
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/wav_front.sv */
module wav_front #(
  parameter int Window = wav_pkg::DEF_WINDOW,
  parameter int SumW = wav_pkg::DEF_SUM_W,
  localparam int SlotW = (Window > 1) ? $clog2(Window) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [wav_pkg::DATA_W-1:0] delta_x_i,
  input  logic signed [wav_pkg::DATA_W-1:0] delta_y_i,
  input  logic signed [wav_pkg::DATA_W-1:0] delta_z_i,
  input  logic        [wav_pkg::DATA_W-1:0] interval_i,
  input  logic                              fifo_full_i,
  output logic                              push_o,
  output logic [wav_pkg::NUM_QTY*SumW-1:0]  push_data_o
);

  import wav_pkg::*;

  localparam int RowW  = NUM_QTY * DATA_W;
  localparam int DiffW = DATA_W + 1;

  front_state_e            state_q, state_d;
  logic [SlotW-1:0]        slot_q, slot_d;
  logic                    full_q, full_d;
  logic [RowW-1:0]         new_q;
  logic [RowW-1:0]         old_row;
  logic signed [DiffW-1:0] diff_q [NUM_QTY];
  logic signed [DiffW-1:0] diff_d [NUM_QTY];
  logic [SumW-1:0]         sum_q [NUM_QTY];
  logic [SumW-1:0]         sum_d [NUM_QTY];
  logic                    accept;

  assign in_stall_o = (state_q != FR_IDLE) || fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  wav_ram #(
    .Width(RowW),
    .Depth(Window)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (state_q == FR_READ),
    .waddr_i(slot_q),
    .wdata_i(new_q),
    .re_i   (accept),
    .raddr_i(slot_q),
    .rdata_o(old_row)
  );

  // The entry leaving the window is subtracted only once the ring has wrapped.
  always_comb begin
    logic [DATA_W-1:0] new_v;
    logic [DATA_W-1:0] old_v;
    logic              new_x;
    logic              old_x;
    for (int k = 0; k < NUM_QTY; k++) begin
      new_v     = new_q[k*DATA_W +: DATA_W];
      old_v     = full_q ? old_row[k*DATA_W +: DATA_W] : '0;
      new_x     = (k < NUM_AXES) ? new_v[DATA_W-1] : 1'b0;
      old_x     = (k < NUM_AXES) ? old_v[DATA_W-1] : 1'b0;
      diff_d[k] = $signed({new_x, new_v}) - $signed({old_x, old_v});
      sum_d[k]  = sum_q[k] + SumW'(diff_q[k]);
    end
  end

  assign push_data_o = {sum_d[3], sum_d[2], sum_d[1], sum_d[0]};

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    full_d  = full_q;
    push_o  = 1'b0;
    unique case (state_q)
      FR_IDLE: begin
        if (accept) begin
          state_d = FR_READ;
        end
      end
      FR_READ: begin
        state_d = FR_ACCUM;
        if (slot_q == SlotW'(Window - 1)) begin
          slot_d = '0;
          full_d = 1'b1;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      FR_ACCUM: begin
        push_o  = 1'b1;
        state_d = FR_IDLE;
      end
      default: begin
        state_d = FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      slot_q  <= '0;
      full_q  <= 1'b0;
      for (int k = 0; k < NUM_QTY; k++) begin
        sum_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      full_q  <= full_d;
      if (state_q == FR_ACCUM) begin
        for (int k = 0; k < NUM_QTY; k++) begin
          sum_q[k] <= sum_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      new_q <= {interval_i, delta_z_i, delta_y_i, delta_x_i};
    end
    if (state_q == FR_READ) begin
      for (int k = 0; k < NUM_QTY; k++) begin
        diff_q[k] <= diff_d[k];
      end
    end
  end

endmodule

/* rtl/wav_back.sv */
module wav_back #(
  parameter int SumW = wav_pkg::DEF_SUM_W
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fifo_empty_i,
  input  logic [wav_pkg::NUM_QTY*SumW-1:0]  fifo_data_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [wav_pkg::DATA_W-1:0] speed_x_o,
  output logic signed [wav_pkg::DATA_W-1:0] speed_y_o,
  output logic signed [wav_pkg::DATA_W-1:0] speed_z_o,
  output logic                              zero_time_o,
  output logic                              clipped_o
);

  import wav_pkg::*;

  localparam int DivW = SumW + 1;
  localparam int NumW = SumW + 1;

  back_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic [SumW-1:0]   den_q;
  logic [DivW-1:0]   dvs_q;
  logic [SumW-1:0]   num_q [NUM_AXES];
  logic              neg_q [NUM_AXES];
  logic              ovf_q [NUM_AXES];
  logic [DivW-1:0]   rem_q [NUM_AXES];
  logic [DATA_W-1:0] quo_q [NUM_AXES];
  logic [NumW-1:0]   n_sum [NUM_AXES];
  logic [DivW:0]     trial [NUM_AXES];
  logic              ge [NUM_AXES];
  logic [DivW-1:0]   rem_next [NUM_AXES];
  logic [DATA_W-1:0] res_val [NUM_AXES];
  logic [NUM_AXES-1:0] res_clip;
  logic              zero_den;
  logic              load_out;
  logic              out_valid_q;
  logic [DATA_W-1:0] speed_q [NUM_AXES];
  logic              zero_time_q;
  logic              clipped_q;

  assign zero_den = (den_q == '0);

  // Each lane divides (2|sum| + den) by 2 den, one quotient bit per cycle.
  always_comb begin
    logic [DATA_W-1:0] q;
    for (int a = 0; a < NUM_AXES; a++) begin
      n_sum[a]    = {num_q[a], 1'b0} + NumW'(den_q);
      trial[a]    = {rem_q[a], quo_q[a][DATA_W-1]};
      ge[a]       = (trial[a] >= {1'b0, dvs_q});
      rem_next[a] = ge[a] ? DivW'(trial[a] - {1'b0, dvs_q}) : trial[a][DivW-1:0];
      q = quo_q[a];
      if (neg_q[a]) begin
        res_clip[a] = ovf_q[a] || (q[DATA_W-1] && (|q[DATA_W-2:0]));
        res_val[a]  = res_clip[a] ? SPEED_MIN : (~q + 1'b1);
      end else begin
        res_clip[a] = ovf_q[a] || q[DATA_W-1];
        res_val[a]  = res_clip[a] ? SPEED_MAX : q;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_NEG;
        end
      end
      BK_NEG: begin
        state_d = zero_den ? BK_DONE : BK_ADD;
      end
      BK_ADD: begin
        state_d = BK_CHECK;
      end
      BK_CHECK: begin
        state_d = BK_DIV;
      end
      BK_DIV: begin
        if (step_q == STEP_W'(DATA_W - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_CHECK) begin
        step_q <= '0;
      end else if (state_q == BK_DIV) begin
        step_q <= step_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      den_q <= fifo_data_i[NUM_AXES*SumW +: SumW];
    end
    if (state_q == BK_NEG) begin
      dvs_q <= {den_q, 1'b0};
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      if (pop_o) begin
        num_q[a] <= fifo_data_i[a*SumW +: SumW];
      end
      if (state_q == BK_NEG) begin
        neg_q[a] <= num_q[a][SumW-1];
        num_q[a] <= num_q[a][SumW-1] ? (~num_q[a] + 1'b1) : num_q[a];
      end
      if (state_q == BK_ADD) begin
        rem_q[a] <= DivW'(n_sum[a][NumW-1:DATA_W]);
        quo_q[a] <= n_sum[a][DATA_W-1:0];
      end
      if (state_q == BK_CHECK) begin
        ovf_q[a] <= (rem_q[a] >= dvs_q);
      end
      if (state_q == BK_DIV) begin
        rem_q[a] <= rem_next[a];
        quo_q[a] <= {quo_q[a][DATA_W-2:0], ge[a]};
      end
    end
    if (load_out) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        speed_q[a] <= zero_den ? '0 : res_val[a];
      end
      zero_time_q <= zero_den;
      clipped_q   <= !zero_den && (|res_clip);
    end
  end

  assign out_valid_o = out_valid_q;
  assign speed_x_o   = speed_q[0];
  assign speed_y_o   = speed_q[1];
  assign speed_z_o   = speed_q[2];
  assign zero_time_o = zero_time_q;
  assign clipped_o   = clipped_q;

endmodule

/* rtl/windowed_average_velocity_top.sv */
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i, in_stall_o  delta_x_i, delta_y_i, delta_z_i, interval_i
// output    out        out_valid_o, out_stall_i speed_x_o, speed_y_o, speed_z_o,
//                                              zero_time_o, clipped_o
//
// The front end takes an item through accept, ring read and difference, then sum update.
// The back end takes magnitudes and, for a nonzero interval sum, runs the three radix-2 divider
// lanes that retire one quotient bit per cycle over 32 steps.
// Reset clears the sums, ring pointer and handshake state; the ring store needs no clearing.
// A two-entry queue of sums lets the front end keep accepting while the divider works,
// and an output register lets the divider start the next item while a result is stalled.
module windowed_average_velocity_top #(
  parameter int WINDOW = wav_pkg::DEF_WINDOW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [wav_pkg::DATA_W-1:0] delta_x_i,
  input  logic signed [wav_pkg::DATA_W-1:0] delta_y_i,
  input  logic signed [wav_pkg::DATA_W-1:0] delta_z_i,
  input  logic        [wav_pkg::DATA_W-1:0] interval_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [wav_pkg::DATA_W-1:0] speed_x_o,
  output logic signed [wav_pkg::DATA_W-1:0] speed_y_o,
  output logic signed [wav_pkg::DATA_W-1:0] speed_z_o,
  output logic                              zero_time_o,
  output logic                              clipped_o
);

  import wav_pkg::*;

  localparam int SUM_W = DATA_W + $clog2(WINDOW);
  localparam int Q_W   = NUM_QTY * SUM_W;

  logic           push;
  logic [Q_W-1:0] push_data;
  logic           pop;
  logic [Q_W-1:0] pop_data;
  logic           fifo_full;
  logic           fifo_empty;

  wav_front #(
    .Window(WINDOW),
    .SumW  (SUM_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .delta_x_i  (delta_x_i),
    .delta_y_i  (delta_y_i),
    .delta_z_i  (delta_z_i),
    .interval_i (interval_i),
    .fifo_full_i(fifo_full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  wav_fifo #(
    .Width(Q_W),
    .Depth(FIFO_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (pop_data),
    .full_o (fifo_full),
    .empty_o(fifo_empty)
  );

  wav_back #(
    .SumW(SUM_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_empty_i(fifo_empty),
    .fifo_data_i (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .speed_x_o   (speed_x_o),
    .speed_y_o   (speed_y_o),
    .speed_z_o   (speed_z_o),
    .zero_time_o (zero_time_o),
    .clipped_o   (clipped_o)
  );

endmodule

/* verif/tb_windowed_average_velocity_top.sv */
`timescale 1ns / 1ps

module tb_windowed_average_velocity_top;

  localparam int          WINDOW     = wav_pkg::DEF_WINDOW;
  localparam int          W          = wav_pkg::DATA_W;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned CYCLE_CAP  = 900_000;
  localparam int          PHASE_LEN  = 380;
  localparam int          BLOCK_LEN  = 25;
  localparam int          DRAIN_WAIT = 100;

  typedef enum int {
    MIX_RAW,
    MIX_MOTION,
    MIX_STILL,
    MIX_BURST,
    MIX_HALF
  } mix_e;

  typedef struct {
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] dz;
    logic        [W-1:0] dt;
  } sample_t;

  typedef struct {
    logic signed [W-1:0] vx;
    logic signed [W-1:0] vy;
    logic signed [W-1:0] vz;
    logic                zero_time;
    logic                clipped;
  } speed_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall_o;
  logic signed [W-1:0] delta_x   = '0;
  logic signed [W-1:0] delta_y   = '0;
  logic signed [W-1:0] delta_z   = '0;
  logic        [W-1:0] interval  = '0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  logic signed [W-1:0] speed_x_o;
  logic signed [W-1:0] speed_y_o;
  logic signed [W-1:0] speed_z_o;
  logic                zero_time_o;
  logic                clipped_o;

  sample_t     pending_samples[$];
  speed_t      speed_q[$];
  sample_t     next_sample;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          long_hold      = 1'b0;
  bit          hold_done      = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned err_count      = 0;
  int unsigned cycle_count    = 0;

  logic signed [W-1:0] ring_x[WINDOW];
  logic signed [W-1:0] ring_y[WINDOW];
  logic signed [W-1:0] ring_z[WINDOW];
  logic        [W-1:0] ring_t[WINDOW];
  logic signed [63:0]  acc_x    = '0;
  logic signed [63:0]  acc_y    = '0;
  logic signed [63:0]  acc_z    = '0;
  logic        [63:0]  acc_t    = '0;
  int unsigned         filled   = 0;
  int unsigned         ring_pos = 0;

  windowed_average_velocity_top #(
    .WINDOW(WINDOW)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .delta_x_i  (delta_x),
    .delta_y_i  (delta_y),
    .delta_z_i  (delta_z),
    .interval_i (interval),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .speed_x_o  (speed_x_o),
    .speed_y_o  (speed_y_o),
    .speed_z_o  (speed_z_o),
    .zero_time_o(zero_time_o),
    .clipped_o  (clipped_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [W-1:0] avg_speed(input logic signed [63:0] num,
                                             input logic [63:0] den, inout logic clip);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] quo;
    neg = num < 0;
    mag = neg ? 64'(-num) : 64'(num);
    quo = ((mag << 1) + den) / (den << 1);
    if (neg) begin
      if (quo > 64'h8000_0000) begin
        clip = 1'b1;
        quo  = 64'h8000_0000;
      end
      quo = -quo;
    end else if (quo > 64'h7FFF_FFFF) begin
      clip = 1'b1;
      quo  = 64'h7FFF_FFFF;
    end
    return quo[W-1:0];
  endfunction

  task automatic advance_window(input sample_t s);
    speed_t v;
    logic   clip;
    if (filled >= WINDOW) begin
      acc_x = acc_x - ring_x[ring_pos];
      acc_y = acc_y - ring_y[ring_pos];
      acc_z = acc_z - ring_z[ring_pos];
      acc_t = acc_t - ring_t[ring_pos];
    end else begin
      filled++;
    end
    ring_x[ring_pos] = s.dx;
    ring_y[ring_pos] = s.dy;
    ring_z[ring_pos] = s.dz;
    ring_t[ring_pos] = s.dt;
    acc_x = acc_x + s.dx;
    acc_y = acc_y + s.dy;
    acc_z = acc_z + s.dz;
    acc_t = acc_t + s.dt;
    ring_pos = (ring_pos + 1 >= WINDOW) ? 0 : ring_pos + 1;
    clip = 1'b0;
    if (acc_t == 0) begin
      v = '{vx: '0, vy: '0, vz: '0, zero_time: 1'b1, clipped: 1'b0};
    end else begin
      v.vx        = avg_speed(acc_x, acc_t, clip);
      v.vy        = avg_speed(acc_y, acc_t, clip);
      v.vz        = avg_speed(acc_z, acc_t, clip);
      v.zero_time = 1'b0;
      v.clipped   = clip;
    end
    speed_q.insert(speed_q.size(), v);
  endtask

  function automatic sample_t rand_sample(input mix_e mix);
    sample_t     s;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    rx = $urandom();
    ry = $urandom();
    rz = $urandom();
    case (mix)
      MIX_MOTION: begin
        s.dx = {{12{rx[19]}}, rx[19:0]};
        s.dy = {{12{ry[19]}}, ry[19:0]};
        s.dz = {{12{rz[19]}}, rz[19:0]};
        s.dt = $urandom_range(32'h0002_0000, 32'h0000_0040);
      end
      MIX_STILL: begin
        s.dx = {{16{rx[15]}}, rx[15:0]};
        s.dy = ry;
        s.dz = {{24{rz[7]}}, rz[7:0]};
        s.dt = '0;
      end
      MIX_BURST: begin
        s.dx = rx;
        s.dy = ry;
        s.dz = rz;
        s.dt = $urandom_range(3);
      end
      MIX_HALF: begin
        s.dx = {{28{rx[3]}}, rx[3:0]};
        s.dy = {{28{ry[3]}}, ry[3:0]};
        s.dz = {{28{rz[3]}}, rz[3:0]};
        s.dt = $urandom_range(4, 1);
      end
      default: begin
        s.dx = rx;
        s.dy = ry;
        s.dz = rz;
        s.dt = $urandom();
      end
    endcase
    return s;
  endfunction

  task automatic queue_sample(input sample_t s);
    pending_samples.insert(pending_samples.size(), s);
  endtask

  task automatic flag_result(input string why, input speed_t want, input speed_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%s: expected x=%0d y=%0d z=%0d zt=%b cl=%b, got x=%0d y=%0d z=%0d zt=%b cl=%b",
               why, want.vx, want.vy, want.vz, want.zero_time, want.clipped,
               got.vx, got.vy, got.vz, got.zero_time, got.clipped);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        advance_window('{dx: delta_x, dy: delta_y, dz: delta_z, dt: interval});
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_sample = pending_samples.pop_front();
          delta_x  <= next_sample.dx;
          delta_y  <= next_sample.dy;
          delta_z  <= next_sample.dz;
          interval <= next_sample.dt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (long_hold && !hold_done) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    speed_t got;
    speed_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      got = '{vx: speed_x_o, vy: speed_y_o, vz: speed_z_o,
              zero_time: zero_time_o, clipped: clipped_o};
      if (speed_q.size() == 0) begin
        flag_result("unexpected result", '{default: 'x}, got);
      end else begin
        want = speed_q.pop_front();
        if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
            got.zero_time !== want.zero_time || got.clipped !== want.clipped) begin
          flag_result("mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_windowed_average_velocity_top: done, errors");
      $finish;
    end
  end

  initial begin
    mix_e mix;
    int   left;
    sample_t s;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero interval sums, both saturation bounds, extreme intervals and halfway ties.
    queue_sample('{dx: 0, dy: 0, dz: 0, dt: 0});
    queue_sample('{dx: 32'sh7FFF_FFFF, dy: 32'sh8000_0000, dz: 1, dt: 0});
    queue_sample('{dx: 1, dy: -1, dz: 0, dt: 1});
    queue_sample('{dx: 32'sh7FFF_FFFF, dy: 32'sh8000_0000, dz: -1, dt: 0});
    queue_sample('{dx: 0, dy: 0, dz: 0, dt: 32'hFFFF_FFFF});
    queue_sample('{dx: 32'sh8000_0000, dy: 32'sh7FFF_FFFF, dz: 32'sh8000_0000,
                   dt: 32'hFFFF_FFFF});
    queue_sample('{dx: 32'sh8000_0000, dy: 32'sh8000_0000, dz: 32'sh8000_0000,
                   dt: 32'hFFFF_FFFF});
    queue_sample('{dx: 32'sh7FFF_FFFF, dy: 32'sh7FFF_FFFF, dz: 32'sh7FFF_FFFF,
                   dt: 32'h0001_0000});
    for (int i = 0; i < 17; i++) begin
      queue_sample('{dx: (i % 2) ? 3 : -3, dy: i - 8, dz: 32'sh0001_8000,
                     dt: 32'd2 + i % 3});
    end

    for (int p = 0; p < 5; p++) begin
      case (p)
        1:       begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 78; end
        3:       begin send_idle_pct = 27; recv_stall_pct = 27; end
        4:       begin send_idle_pct = 0;  recv_stall_pct = 0;  long_hold = 1'b1; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      left = PHASE_LEN;
      while (left > 0) begin
        mix = mix_e'($urandom_range(MIX_HALF, MIX_RAW));
        for (int k = 0; k < BLOCK_LEN && left > 0; k++) begin
          s = rand_sample(mix);
          queue_sample(s);
          left--;
        end
      end
      do @(negedge clk_i); while (pending_samples.size() != 0);
    end

    do @(negedge clk_i); while (in_valid || speed_q.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (err_count == 0) begin
      $display("tb_windowed_average_velocity_top: done, clean");
    end else begin
      $display("tb_windowed_average_velocity_top: done, errors");
    end
    $finish;
  end

endmodule
